// ----- rtl/cpp_pkg.sv -----
package cpp_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int PRODUCT_WIDTH = 2 * OPERAND_WIDTH + 1;
	localparam int MAG_WIDTH = 2 * OPERAND_WIDTH;
	localparam int RADICAND_WIDTH = 2 * MAG_WIDTH;
	localparam int SQRT_STEPS = MAG_WIDTH;
	localparam int REM_WIDTH = MAG_WIDTH + 2;

	localparam int CORDIC_STAGES = 16;
	localparam int CORDIC_WIDTH = 64;
	localparam int GUARD_SHIFT = 28;
	localparam int ANGLE_WIDTH = 32;
	localparam int PHASE_WIDTH = 16;
	localparam int PHASE_SHIFT = ANGLE_WIDTH - PHASE_WIDTH;

	// Square, sum, one stage per root bit, rounding.
	localparam int MAG_LATENCY = 3 + SQRT_STEPS;
	// Pre-rotation, one stage per CORDIC step, rounding.
	localparam int CORDIC_LATENCY = 2 + CORDIC_STAGES;
	localparam int PHASE_DELAY = MAG_LATENCY - CORDIC_LATENCY;
	localparam int PIPE_DEPTH = 2 + MAG_LATENCY;

	localparam int APB_ADDR_WIDTH = 3;
	localparam int APB_DATA_WIDTH = 32;
	localparam logic [APB_ADDR_WIDTH-3:0] REG_PHASE_MODE = 1'b0;
	localparam logic PHASE_MODE_ATAN2 = 1'b0;

	typedef logic signed [OPERAND_WIDTH-1:0] operand_t;
	typedef logic signed [PRODUCT_WIDTH-1:0] product_t;
	typedef logic [MAG_WIDTH-1:0] mag_t;
	typedef logic signed [CORDIC_WIDTH-1:0] cordic_word_t;
	typedef logic [ANGLE_WIDTH-1:0] angle_t;
	typedef logic [PHASE_WIDTH-1:0] phase_t;

	// atan(2^-i) with a full turn as 2^32, rounded to nearest.
	function automatic angle_t atan_angle(input int unsigned idx);
		angle_t a;
		case (idx)
			0: a = 32'h20000000;
			1: a = 32'h12E4051E;
			2: a = 32'h09FB385B;
			3: a = 32'h051111D4;
			4: a = 32'h028B0D43;
			5: a = 32'h0145D7E1;
			6: a = 32'h00A2F61E;
			7: a = 32'h00517C55;
			8: a = 32'h0028BE53;
			9: a = 32'h00145F2F;
			10: a = 32'h000A2F98;
			11: a = 32'h000517CC;
			12: a = 32'h00028BE6;
			13: a = 32'h000145F3;
			14: a = 32'h0000A2FA;
			15: a = 32'h0000517D;
			16: a = 32'h000028BE;
			17: a = 32'h0000145F;
			18: a = 32'h00000A30;
			19: a = 32'h00000518;
			20: a = 32'h0000028C;
			21: a = 32'h00000146;
			22: a = 32'h000000A3;
			23: a = 32'h00000051;
			24: a = 32'h00000029;
			25: a = 32'h00000014;
			26: a = 32'h0000000A;
			27: a = 32'h00000005;
			28: a = 32'h00000003;
			29: a = 32'h00000001;
			30: a = 32'h00000001;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ----- rtl/cpp_cmul.sv -----
module cpp_cmul
	import cpp_pkg::*;
(
	input  logic     clk,
	input  logic     en,
	input  operand_t a_real,
	input  operand_t a_imag,
	input  operand_t b_real,
	input  operand_t b_imag,
	output product_t re_s2,
	output product_t im_s2
);

	logic signed [2*OPERAND_WIDTH-1:0] p_rr_s1;
	logic signed [2*OPERAND_WIDTH-1:0] p_jj_s1;
	logic signed [2*OPERAND_WIDTH-1:0] p_rj_s1;
	logic signed [2*OPERAND_WIDTH-1:0] p_jr_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p_rr_s1 <= a_real * b_real;
			p_jj_s1 <= a_imag * b_imag;
			p_rj_s1 <= a_real * b_imag;
			p_jr_s1 <= a_imag * b_real;
			re_s2 <= PRODUCT_WIDTH'(p_rr_s1) - PRODUCT_WIDTH'(p_jj_s1);
			im_s2 <= PRODUCT_WIDTH'(p_rj_s1) + PRODUCT_WIDTH'(p_jr_s1);
		end
	end

endmodule

// ----- rtl/cpp_mag.sv -----
module cpp_mag
	import cpp_pkg::*;
(
	input  logic     clk,
	input  logic     en,
	input  product_t re,
	input  product_t im,
	output mag_t     magnitude
);

	logic [PRODUCT_WIDTH-1:0] re_abs;
	logic [PRODUCT_WIDTH-1:0] im_abs;
	logic [RADICAND_WIDTH-1:0] sq_re_s3;
	logic [RADICAND_WIDTH-1:0] sq_im_s3;
	logic [RADICAND_WIDTH-1:0] sum_s4;

	logic [REM_WIDTH-1:0] rem_s [1:SQRT_STEPS];
	mag_t root_s [1:SQRT_STEPS];
	logic [RADICAND_WIDTH-1:0] rad_s [1:SQRT_STEPS];

	logic rnd_up;

	assign re_abs = re[PRODUCT_WIDTH-1] ? PRODUCT_WIDTH'(-re) : PRODUCT_WIDTH'(re);
	assign im_abs = im[PRODUCT_WIDTH-1] ? PRODUCT_WIDTH'(-im) : PRODUCT_WIDTH'(im);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_re_s3 <= re_abs[MAG_WIDTH-1:0] * re_abs[MAG_WIDTH-1:0];
			sq_im_s3 <= im_abs[MAG_WIDTH-1:0] * im_abs[MAG_WIDTH-1:0];
			sum_s4 <= sq_re_s3 + sq_im_s3;
		end
	end

	// Restoring square root, one root bit per stage.
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic [REM_WIDTH-1:0] rem_prev;
		mag_t root_prev;
		logic [RADICAND_WIDTH-1:0] rad_prev;
		logic [REM_WIDTH+1:0] rem_trial;
		logic [REM_WIDTH+1:0] sub;
		logic ge;

		if (k == 0) begin : g_first
			assign rem_prev = '0;
			assign root_prev = '0;
			assign rad_prev = sum_s4;
		end else begin : g_next
			assign rem_prev = rem_s[k];
			assign root_prev = root_s[k];
			assign rad_prev = rad_s[k];
		end

		assign rem_trial = {rem_prev, rad_prev[RADICAND_WIDTH-1 -: 2]};
		assign sub = (REM_WIDTH+2)'({root_prev, 2'b01});
		assign ge = rem_trial >= sub;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? REM_WIDTH'(rem_trial - sub) : REM_WIDTH'(rem_trial);
				root_s[k+1] <= {root_prev[MAG_WIDTH-2:0], ge};
				rad_s[k+1] <= {rad_prev[RADICAND_WIDTH-3:0], 2'b00};
			end
		end
	end

	assign rnd_up = rem_s[SQRT_STEPS] > REM_WIDTH'(root_s[SQRT_STEPS]);

	always_ff @(posedge clk) begin
		if (en) begin
			magnitude <= root_s[SQRT_STEPS] + MAG_WIDTH'(rnd_up);
		end
	end

endmodule

// ----- rtl/cpp_cordic.sv -----
module cpp_cordic
	import cpp_pkg::*;
(
	input  logic     clk,
	input  logic     en,
	input  logic     full_circle,
	input  product_t re,
	input  product_t im,
	output phase_t   phase
);

	cordic_word_t x_in;
	cordic_word_t y_in;

	cordic_word_t x_s [0:CORDIC_STAGES];
	cordic_word_t y_s [0:CORDIC_STAGES];
	angle_t z_s [0:CORDIC_STAGES];

	angle_t z_rnd;

	// The imaginary part is the cosine side, the real part the sine side.
	assign x_in = cordic_word_t'(im) <<< GUARD_SHIFT;
	assign y_in = cordic_word_t'(re) <<< GUARD_SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (x_in[CORDIC_WIDTH-1] && full_circle) begin
				x_s[0] <= -x_in;
				y_s[0] <= -y_in;
				z_s[0] <= {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
			end else if (x_in[CORDIC_WIDTH-1]) begin
				x_s[0] <= -x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_step
		cordic_word_t dx;
		cordic_word_t dy;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[i][CORDIC_WIDTH-1]) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + atan_angle(i);
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - atan_angle(i);
				end
			end
		end
	end

	assign z_rnd = z_s[CORDIC_STAGES] + (ANGLE_WIDTH'(1) << (PHASE_SHIFT - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			phase <= z_rnd[ANGLE_WIDTH-1:PHASE_SHIFT];
		end
	end

endmodule

// ----- rtl/complex_product_phase_core.sv -----
// Complex product with magnitude and phase.
// Each input item on the s_axis channel carries two complex operands a and b.
// The result item on the m_axis channel holds the exact product a*b, its
// magnitude rounded to the nearest integer, and its phase as a binary angle
// in which 32768 stands for pi; tuser flags a zero product, whose phase and
// magnitude are 0. The phase_mode register selects a full-circle atan2
// phase (0) or an arcsine phase held to plus or minus a quarter turn (1).
// The pipeline takes one item per clock cycle while s_axis_tready is high. Its
// depth is set by the square root, which resolves one root bit per stage,
// with the CORDIC running beside it.
// Reset empties the pipeline and the output register and sets phase_mode
// to 0. When the receiver stalls, the output register holds its item and a
// second buffer catches the next one; s_axis_tready then drops and the whole
// pipeline holds until the buffer is freed.
module complex_product_phase_core
	import cpp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_WIDTH-1:0] paddr,
	input  logic [APB_DATA_WIDTH-1:0] pwdata,
	output logic [APB_DATA_WIDTH-1:0] prdata,
	output logic                      pready,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// a_real, a_imag, b_real, b_imag
	input  logic [63:0]               s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// product_real, product_imag, magnitude, phase, zero padding
	output logic [119:0]              m_axis_tdata,
	// zero_vector
	output logic [0:0]                m_axis_tuser
);

	logic mode_q;
	logic en;
	logic push;
	logic [PIPE_DEPTH-1:0] valid_s;

	product_t re_s2;
	product_t im_s2;
	logic zero_s2;
	mag_t mag_d;
	phase_t phase_c;

	product_t re_dly_s [0:MAG_LATENCY-1];
	product_t im_dly_s [0:MAG_LATENCY-1];
	logic zero_dly_s [0:MAG_LATENCY-1];
	phase_t phase_dly_s [0:PHASE_DELAY-1];

	logic [119:0] new_data;
	logic [119:0] out_data_q;
	logic [119:0] skid_data_q;
	logic out_user_q;
	logic skid_user_q;
	logic out_valid_q;
	logic skid_valid_q;

	assign pready = 1'b1;
	assign prdata = (paddr[APB_ADDR_WIDTH-1:2] == REG_PHASE_MODE)
		? APB_DATA_WIDTH'(mode_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready
				&& paddr[APB_ADDR_WIDTH-1:2] == REG_PHASE_MODE) begin
			mode_q <= pwdata[0];
		end
	end

	assign en = !skid_valid_q;
	assign s_axis_tready = en;
	assign push = en && valid_s[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[PIPE_DEPTH-2:0], s_axis_tvalid};
		end
	end

	cpp_cmul u_cmul (
		.clk    (clk),
		.en     (en),
		.a_real (operand_t'(s_axis_tdata[15:0])),
		.a_imag (operand_t'(s_axis_tdata[31:16])),
		.b_real (operand_t'(s_axis_tdata[47:32])),
		.b_imag (operand_t'(s_axis_tdata[63:48])),
		.re_s2  (re_s2),
		.im_s2  (im_s2)
	);

	assign zero_s2 = (re_s2 == '0) && (im_s2 == '0);

	cpp_mag u_mag (
		.clk       (clk),
		.en        (en),
		.re        (re_s2),
		.im        (im_s2),
		.magnitude (mag_d)
	);

	cpp_cordic u_cordic (
		.clk         (clk),
		.en          (en),
		.full_circle (mode_q == PHASE_MODE_ATAN2),
		.re          (re_s2),
		.im          (im_s2),
		.phase       (phase_c)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			re_dly_s[0] <= re_s2;
			im_dly_s[0] <= im_s2;
			zero_dly_s[0] <= zero_s2;
			for (int i = 1; i < MAG_LATENCY; i++) begin
				re_dly_s[i] <= re_dly_s[i-1];
				im_dly_s[i] <= im_dly_s[i-1];
				zero_dly_s[i] <= zero_dly_s[i-1];
			end
			phase_dly_s[0] <= phase_c;
			for (int i = 1; i < PHASE_DELAY; i++) begin
				phase_dly_s[i] <= phase_dly_s[i-1];
			end
		end
	end

	assign new_data = {
		6'b0,
		zero_dly_s[MAG_LATENCY-1] ? phase_t'(0) : phase_dly_s[PHASE_DELAY-1],
		mag_d,
		im_dly_s[MAG_LATENCY-1],
		re_dly_s[MAG_LATENCY-1]
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_axis_tready) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
				out_user_q <= skid_user_q;
			end else if (push) begin
				out_data_q <= new_data;
				out_user_q <= zero_dly_s[MAG_LATENCY-1];
			end
		end else if (push) begin
			skid_data_q <= new_data;
			skid_user_q <= zero_dly_s[MAG_LATENCY-1];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_user_q;

endmodule

// ----- tb/testbench.sv -----
module testbench;
	import cpp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic PHASE_MODE_ASIN = ~PHASE_MODE_ATAN2;
	localparam logic [APB_ADDR_WIDTH-1:0] MODE_ADDR = {REG_PHASE_MODE, 2'b00};
	localparam logic [APB_ADDR_WIDTH-1:0] UNMAPPED_ADDR = 3'd4;
	localparam int RANDOM_ITEMS = 1350;
	localparam int PHASE_ITEMS = 225;

	typedef struct packed {
		operand_t b_imag;
		operand_t b_real;
		operand_t a_imag;
		operand_t a_real;
	} operand_pair_t;

	typedef struct packed {
		logic [5:0] pad;
		phase_t     phase;
		mag_t       magnitude;
		product_t   product_imag;
		product_t   product_real;
	} result_word_t;

	typedef struct packed {
		product_t re;
		product_t im;
		mag_t     mag;
		phase_t   ph;
		logic     zero;
	} cplx_result_t;

	typedef struct packed {
		logic         typed;
		cplx_result_t want;
	} forecast_hint_t;

	typedef struct packed {
		logic         mode;
		operand_t     ar, aj, br, bj;
		logic         typed;
		cplx_result_t want;
	} stim_row_t;

	localparam cplx_result_t NULL_PRODUCT = '{re: '0, im: '0, mag: '0, ph: '0, zero: 1'b1};
	localparam cplx_result_t NO_FORECAST = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_WIDTH-1:0] paddr = '0;
	logic [APB_DATA_WIDTH-1:0] pwdata = '0;
	logic [APB_DATA_WIDTH-1:0] prdata;
	logic pready;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [119:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;

	logic mode_shadow = PHASE_MODE_ATAN2;
	logic steady = 1'b0;
	int errors = 0;
	int items_sent = 0;
	int results_checked = 0;
	int mode_writes = 0;

	cplx_result_t pending_products[$];
	forecast_hint_t forecast_hints[$];

	angle_t arctan_step [16] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};

	stim_row_t script [23] = '{
		'{PHASE_MODE_ATAN2, 16'sd0, 16'sd0, 16'sd32767, 16'sh8000, 1'b1, NULL_PRODUCT},
		'{PHASE_MODE_ATAN2, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 1'b1, NULL_PRODUCT},
		'{PHASE_MODE_ATAN2, 16'sd1, 16'sd0, 16'sd1, 16'sd0, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ATAN2, 16'sd0, 16'sd1, 16'sd0, 16'sd1, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ATAN2, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ATAN2, 16'sd1, 16'sd0, 16'sd0, -16'sd1, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ATAN2, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ATAN2, 16'sh8000, 16'sh8000, 16'sd32767, 16'sd32767, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ATAN2, 16'sd32767, 16'sd32767, 16'sd32767, -16'sd32767, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ATAN2, 16'sh8000, 16'sd32767, 16'sh8000, -16'sd32767, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ATAN2, 16'sd1, 16'sd0, 16'sd1, 16'sh8000, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ATAN2, 16'sd1, 16'sd0, -16'sd1, 16'sh8000, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ATAN2, 16'sd3, 16'sd4, 16'sd1, 16'sd0, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ATAN2, 16'sd32767, 16'sh8000, 16'sd32767, 16'sh8000, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ATAN2, 16'sd12345, -16'sd23456, -16'sd31111, 16'sd777, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ASIN, 16'sd1, 16'sd0, 16'sd0, -16'sd1, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ASIN, 16'sd1, 16'sd0, 16'sd1, 16'sh8000, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ASIN, 16'sd1, 16'sd0, -16'sd1, 16'sh8000, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ASIN, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ASIN, 16'sd0, 16'sd0, 16'sd5, 16'sd5, 1'b1, NULL_PRODUCT},
		'{PHASE_MODE_ASIN, 16'sd1, 16'sd0, 16'sd1, 16'sd0, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ASIN, 16'sd0, 16'sd1, 16'sd0, 16'sd1, 1'b0, NO_FORECAST},
		'{PHASE_MODE_ASIN, 16'sd32767, 16'sd32767, 16'sd32767, -16'sd32767, 1'b0, NO_FORECAST}
	};

	complex_product_phase_core DUT (
		.clk,
		.arst_n,
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata,
		.m_axis_tuser
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic phase_t cordic_phase(input longint cos_side, input longint sin_side,
			input logic full_circle);
		longint x, y, dx, dy;
		angle_t z, p;
		x = cos_side <<< GUARD_SHIFT;
		y = sin_side <<< GUARD_SHIFT;
		z = '0;
		if (x < 0) begin
			x = -x;
			if (full_circle) begin
				y = -y;
				z = 32'h8000_0000;
			end
		end
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				z = z + arctan_step[i];
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - arctan_step[i];
			end
		end
		p = (z + (angle_t'(1) << (PHASE_SHIFT - 1))) >> PHASE_SHIFT;
		return p[PHASE_WIDTH-1:0];
	endfunction

	function automatic mag_t rounded_root(input longint unsigned s);
		mag_t r;
		mag_t trial;
		longint unsigned t;
		r = '0;
		for (int b = MAG_WIDTH - 1; b >= 0; b--) begin
			trial = r | (mag_t'(1) << b);
			t = {32'b0, trial};
			if (t * t <= s)
				r = trial;
		end
		t = {32'b0, r};
		if (s - t * t > t && r != '1)
			r = r + 1'b1;
		return r;
	endfunction

	function automatic cplx_result_t forecast_product(input operand_pair_t ops,
			input logic mode);
		cplx_result_t r;
		logic [63:0] re_w, im_w;
		longint re, im;
		longint unsigned ax, ay;
		re_w = longint'($signed(ops.a_real)) * longint'($signed(ops.b_real))
			- longint'($signed(ops.a_imag)) * longint'($signed(ops.b_imag));
		im_w = longint'($signed(ops.a_real)) * longint'($signed(ops.b_imag))
			+ longint'($signed(ops.a_imag)) * longint'($signed(ops.b_real));
		r.re = re_w[PRODUCT_WIDTH-1:0];
		r.im = im_w[PRODUCT_WIDTH-1:0];
		re = longint'($signed(r.re));
		im = longint'($signed(r.im));
		r.zero = (re == 0 && im == 0);
		r.mag = '0;
		r.ph = '0;
		if (!r.zero) begin
			r.ph = cordic_phase(im, re, mode == PHASE_MODE_ATAN2);
			ax = re < 0 ? -re : re;
			ay = im < 0 ? -im : im;
			r.mag = rounded_root(ax * ax + ay * ay);
		end
		return r;
	endfunction

	function automatic operand_t random_part();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sd32767;
			2: return '0;
			3: return operand_t'(int'($urandom_range(2)) - 1);
			4, 5: return operand_t'(int'($urandom_range(16)) - 8);
			default: return operand_t'($urandom);
		endcase
	endfunction

	function automatic operand_pair_t random_operands();
		operand_pair_t p;
		p.a_real = random_part();
		p.a_imag = random_part();
		p.b_real = random_part();
		p.b_imag = random_part();
		case ($urandom_range(9))
			0: begin
				if ($urandom_range(1)) begin
					p.a_real = '0;
					p.a_imag = '0;
				end else begin
					p.b_real = '0;
					p.b_imag = '0;
				end
			end
			1: begin
				p.a_imag = '0;
				p.b_imag = '0;
			end
			2: begin
				p.a_imag = '0;
				p.b_real = '0;
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic reg_write(input logic [APB_ADDR_WIDTH-1:0] addr,
			input logic [APB_DATA_WIDTH-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == MODE_ADDR)
			mode_shadow = data[0];
		mode_writes++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_products.size() != 0 || forecast_hints.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_item(input operand_pair_t ops, input logic typed,
			input cplx_result_t want);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 12) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		forecast_hints.push_back('{typed: typed, want: want});
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ops;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	always @(negedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= 12);
	end

	always @(posedge clk) begin : watch
		forecast_hint_t hint;
		cplx_result_t got, want;
		result_word_t word;
		if (s_axis_tvalid && s_axis_tready) begin
			hint = forecast_hints.pop_front();
			pending_products.push_back(hint.typed ? hint.want
				: forecast_product(s_axis_tdata, mode_shadow));
			items_sent++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			word = m_axis_tdata;
			got = '{re: word.product_real, im: word.product_imag, mag: word.magnitude,
				ph: word.phase, zero: m_axis_tuser[0]};
			if (pending_products.size() == 0) begin
				$error("result item arrived with no item pending");
				errors++;
			end else begin
				want = pending_products.pop_front();
				results_checked++;
				if (got.re !== want.re) begin
					$error("product_real: expected %0d, got %0d", $signed(want.re),
						$signed(got.re));
					errors++;
				end
				if (got.im !== want.im) begin
					$error("product_imag: expected %0d, got %0d", $signed(want.im),
						$signed(got.im));
					errors++;
				end
				if (got.mag !== want.mag) begin
					$error("magnitude: expected %0d, got %0d", want.mag, got.mag);
					errors++;
				end
				if (got.ph !== want.ph) begin
					$error("phase: expected %0d, got %0d", $signed(want.ph), $signed(got.ph));
					errors++;
				end
				if (got.zero !== want.zero) begin
					$error("zero_vector: expected %0b, got %0b", want.zero, got.zero);
					errors++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		operand_pair_t ops;
		logic [APB_DATA_WIDTH-1:0] data;
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < $size(script); r++) begin
			if (script[r].mode != mode_shadow) begin
				drain();
				reg_write(MODE_ADDR, {31'b0, script[r].mode});
			end
			ops.a_real = script[r].ar;
			ops.a_imag = script[r].aj;
			ops.b_real = script[r].br;
			ops.b_imag = script[r].bj;
			send_item(ops, script[r].typed, script[r].want);
		end

		// Upper bits of the mode register are dropped, and the unmapped slot is ignored.
		drain();
		reg_write(MODE_ADDR, 32'hFFFF_FFFE);
		reg_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n > 0 && n % PHASE_ITEMS == 0) begin
				drain();
				data = $urandom;
				data[0] = ~mode_shadow;
				reg_write(MODE_ADDR, data);
			end
			steady = (n >= 500 && n < 800);
			send_item(random_operands(), 1'b0, NO_FORECAST);
		end
		steady = 1'b0;

		drain();
		repeat (PIPE_DEPTH + 8)
			@(negedge clk);

		$display("Checked %0d results from %0d items across %0d register writes,",
			results_checked, items_sent, mode_writes);
		$display("covering both phase modes, axis and zero products, and stalls on both sides.");
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
